>>> rtl/msrt_pkg.sv
// ----------------------------------------------------------------------------
// msrt_pkg
// Shared types and codes for the message rate statistics table.
// ----------------------------------------------------------------------------
package msrt_pkg;

  // result status codes
  typedef enum logic [2:0] {
    ST_UPDATED = 3'd0,
    ST_NEW     = 3'd1,
    ST_FULL    = 3'd2,
    ST_READ    = 3'd3,
    ST_EMPTY   = 3'd4
  } status_t;

  // kind of an incoming transaction
  typedef enum logic {
    CMD_ARRIVAL = 1'b0,
    CMD_READ    = 1'b1
  } cmd_kind_t;

  // classified transaction passed from front to back
  typedef struct packed {
    cmd_kind_t   kind;
    logic [15:0] msg_type;
    logic [63:0] timestamp_us;
    logic [6:0]  entry_index;
  } cmd_t;

  // one table entry as stored in memory
  typedef struct packed {
    logic [15:0] key;
    logic [31:0] count;
    logic [63:0] last_time;
    logic [31:0] avg;
    logic [31:0] max;
    logic [31:0] min;
  } entry_t;

  // one result transaction
  typedef struct packed {
    status_t     status;
    logic [15:0] entry_key;
    logic [31:0] arrival_count;
    logic [31:0] avg_period;
    logic [31:0] max_period;
    logic [31:0] min_period;
  } result_t;

  // back-end sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_RDWAIT,
    S_SCAN,
    S_MISS,
    S_MUL,
    S_DIVGO,
    S_DIV,
    S_WB,
    S_OUT
  } eng_state_t;

endpackage

>>> rtl/msrt_ram.sv
// ----------------------------------------------------------------------------
// msrt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module msrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/msrt_front.sv
// ----------------------------------------------------------------------------
// msrt_front
// Input side: accepts transactions, classifies them, two-entry queue.
// ----------------------------------------------------------------------------
module msrt_front
  import msrt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_op,
  input  logic [15:0] in_msg_type,
  input  logic [63:0] in_timestamp_us,
  input  logic [6:0]  in_entry_index,
  output logic        q_valid,
  output cmd_t        q_cmd,
  input  logic        q_pop
);

  cmd_t       slot_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push_ok;
  logic       pop_ok;
  cmd_t       cmd_in;

  // classify the incoming transaction
  always_comb begin
    cmd_in.kind         = in_op ? CMD_READ : CMD_ARRIVAL;
    cmd_in.msg_type     = in_msg_type;
    cmd_in.timestamp_us = in_timestamp_us;
    cmd_in.entry_index  = in_entry_index;
  end

  assign in_full = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = slot_r[rptr_r];
  assign push_ok = in_push && !in_full;
  assign pop_ok  = q_pop && q_valid;

  // pointer and count update
  always_comb begin
    wptr_nxt = push_ok ? ~wptr_r : wptr_r;
    rptr_nxt = pop_ok ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push_ok} - {1'b0, pop_ok};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push_ok) begin
      slot_r[wptr_r] <= cmd_in;
    end
  end

endmodule

>>> rtl/msrt_div.sv
// ----------------------------------------------------------------------------
// msrt_div
// 32-bit unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module msrt_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic [32:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] dvs_r;
  logic [5:0]  step_r, step_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] shifted;

  assign shifted = {rem_r[31:0], quo_r[31]};

  // one shift-subtract step
  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[30:0], 1'b0};
      if (shifted >= {1'b0, dvs_r}) begin
        rem_nxt    = shifted - {1'b0, dvs_r};
        quo_nxt[0] = 1'b1;
      end else begin
        rem_nxt = shifted;
      end
      step_nxt = step_r + 6'd1;
      if (step_r == 6'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> rtl/msrt_engine.sv
// ----------------------------------------------------------------------------
// msrt_engine
// Back end: key search, statistics update, read and clear, table memory.
// ----------------------------------------------------------------------------
module msrt_engine
  import msrt_pkg::*;
#(
  parameter int TABLE_DEPTH = 128
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_valid,
  input  cmd_t    q_cmd,
  output logic    q_pop,
  output logic    res_vld,
  output result_t res,
  input  logic    res_rdy
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int FW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = $bits(entry_t);

  eng_state_t    state_r, state_nxt;
  logic [FW-1:0] fill_r;
  cmd_t          cur_r;
  logic [AW-1:0] scan_r;
  logic [AW-1:0] hit_r;
  logic [31:0]   cnt_r, period_r, avg_r, max_r, min_r, prod_r;
  result_t       res_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, ent;
  logic [EW-1:0] ram_rdata;

  logic          div_start, div_done;
  logic [31:0]   div_q;

  logic [31:0]   period_c, cnt_c, max_c, min_c;
  logic          key_hit, scan_last, read_empty, table_full;

  msrt_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  msrt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r + period_r),
    .divisor  (cnt_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign ent = entry_t'(ram_rdata);

  // per-entry update terms from the entry just read
  always_comb begin
    period_c = cur_r.timestamp_us[31:0] - ent.last_time[31:0];
    cnt_c    = (ent.count == 32'hFFFF_FFFF) ? ent.count : ent.count + 32'd1;
    max_c    = (ent.max < period_c) ? period_c : ent.max;
    min_c    = (ent.min == 32'd0 || ent.min > period_c) ? period_c : ent.min;
  end

  assign key_hit    = (ent.key == cur_r.msg_type);
  assign scan_last  = ((FW'(scan_r) + FW'(1)) >= fill_r);
  assign read_empty = (32'(q_cmd.entry_index) >= 32'(fill_r));
  assign table_full = (fill_r == FW'(TABLE_DEPTH));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          if (q_cmd.kind == CMD_READ) begin
            state_nxt = read_empty ? S_OUT : S_RDWAIT;
          end else begin
            state_nxt = (fill_r == '0) ? S_MISS : S_SCAN;
          end
        end
      end
      S_RDWAIT: state_nxt = S_OUT;
      S_SCAN: begin
        if (key_hit) begin
          state_nxt = (ent.avg == 32'd0) ? S_WB : S_MUL;
        end else if (scan_last) begin
          state_nxt = S_MISS;
        end
      end
      S_MISS:  state_nxt = S_OUT;
      S_MUL:   state_nxt = S_DIVGO;
      S_DIVGO: state_nxt = S_DIV;
      S_DIV:   state_nxt = div_done ? S_WB : S_DIV;
      S_WB:    state_nxt = S_OUT;
      S_OUT:   state_nxt = res_rdy ? S_IDLE : S_OUT;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs: queue pop, memory port, divider start, result valid
  always_comb begin
    q_pop     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    div_start = 1'b0;
    res_vld   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        q_pop = q_valid;
        if (q_cmd.kind == CMD_READ) begin
          ram_raddr = AW'(q_cmd.entry_index);
        end
      end
      S_RDWAIT: begin
        ram_we              = 1'b1;
        ram_waddr           = AW'(cur_r.entry_index);
        ram_wdata           = '0;
        ram_wdata.key       = ent.key;
        ram_wdata.last_time = ent.last_time;
      end
      S_SCAN: ram_raddr = scan_r + AW'(1);
      S_MISS: begin
        if (!table_full) begin
          ram_we              = 1'b1;
          ram_waddr           = AW'(fill_r);
          ram_wdata           = '0;
          ram_wdata.key       = cur_r.msg_type;
          ram_wdata.count     = 32'd1;
          ram_wdata.last_time = cur_r.timestamp_us;
        end
      end
      S_DIVGO: div_start = 1'b1;
      S_WB: begin
        ram_we    = 1'b1;
        ram_waddr = hit_r;
        ram_wdata = '{key: cur_r.msg_type, count: cnt_r, last_time: cur_r.timestamp_us,
                      avg: avg_r, max: max_r, min: min_r};
      end
      S_OUT: res_vld = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_MISS && !table_full) begin
        fill_r <= fill_r + FW'(1);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        cur_r  <= q_cmd;
        scan_r <= '0;
        res_r  <= '{status: ST_EMPTY, default: '0};
      end
      S_RDWAIT: begin
        res_r <= '{status: ST_READ, entry_key: ent.key, arrival_count: ent.count,
                   avg_period: ent.avg, max_period: ent.max, min_period: ent.min};
      end
      S_SCAN: begin
        scan_r   <= scan_r + AW'(1);
        hit_r    <= scan_r;
        cnt_r    <= cnt_c;
        period_r <= period_c;
        avg_r    <= (ent.avg == 32'd0) ? period_c : ent.avg;
        max_r    <= max_c;
        min_r    <= min_c;
      end
      S_MISS: begin
        if (table_full) begin
          res_r <= '{status: ST_FULL, entry_key: cur_r.msg_type, default: '0};
        end else begin
          res_r <= '{status: ST_NEW, entry_key: cur_r.msg_type, arrival_count: 32'd1,
                     default: '0};
        end
      end
      S_MUL: prod_r <= 32'(avg_r * (cnt_r - 32'd1));
      S_DIV: begin
        if (div_done) begin
          avg_r <= div_q;
        end
      end
      S_WB: begin
        res_r <= '{status: ST_UPDATED, entry_key: cur_r.msg_type, arrival_count: cnt_r,
                   avg_period: avg_r, max_period: max_r, min_period: min_r};
      end
      default: begin
      end
    endcase
  end

  assign res = res_r;

endmodule

>>> rtl/message_rate_statistics_table.sv
// ----------------------------------------------------------------------------
// message_rate_statistics_table
// Per-message-type arrival statistics with read-and-clear access.
// ----------------------------------------------------------------------------
// One transaction at a time is processed. A read passes a read-wait state and
// then the output state, or goes straight to the output state when the entry
// is not filled. An arrival is taken in the idle state, then scans the filled
// entries one per cycle through the table memory read port. A new entry then
// passes the miss state, a first-period hit the write-back state. A later hit
// adds a multiply state, a divider start state and a wait on the 32-step
// iterative divider before write-back. Two input transactions queue ahead and
// one result waits in an output register. No clearing pass is run after reset.
module message_rate_statistics_table
  import msrt_pkg::*;
#(
  parameter int TABLE_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_op,
  input  logic [15:0] in_msg_type,
  input  logic [63:0] in_timestamp_us,
  input  logic [6:0]  in_entry_index,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [2:0]  out_status,
  output logic [15:0] out_entry_key,
  output logic [31:0] out_arrival_count,
  output logic [31:0] out_avg_period,
  output logic [31:0] out_max_period,
  output logic [31:0] out_min_period
);

  logic    q_valid, q_pop;
  cmd_t    q_cmd;
  logic    res_vld, res_rdy;
  result_t res;
  result_t out_r;
  logic    out_vld_r;

  msrt_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_op           (in_op),
    .in_msg_type     (in_msg_type),
    .in_timestamp_us (in_timestamp_us),
    .in_entry_index  (in_entry_index),
    .q_valid         (q_valid),
    .q_cmd           (q_cmd),
    .q_pop           (q_pop)
  );

  msrt_engine #(.TABLE_DEPTH(TABLE_DEPTH)) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .res_vld (res_vld),
    .res     (res),
    .res_rdy (res_rdy)
  );

  // output register
  assign res_rdy = !out_vld_r || out_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_rdy) begin
      out_vld_r <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (res_rdy && res_vld) begin
      out_r <= res;
    end
  end

  assign out_empty         = !out_vld_r;
  assign out_status        = out_r.status;
  assign out_entry_key     = out_r.entry_key;
  assign out_arrival_count = out_r.arrival_count;
  assign out_avg_period    = out_r.avg_period;
  assign out_max_period    = out_r.max_period;
  assign out_min_period    = out_r.min_period;

`ifndef SYNTH
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status == ST_FULL) |->
      (out_arrival_count == 32'd0 && out_avg_period == 32'd0 && out_max_period == 32'd0))
    else $error("dropped arrival carries statistics");

  a_new_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status == ST_NEW) |->
      (out_arrival_count == 32'd1 && out_min_period == 32'd0))
    else $error("new entry not freshly initialized");

  a_update_count: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status == ST_UPDATED) |-> (out_arrival_count != 32'd0))
    else $error("updated entry has zero count");
`endif

endmodule
